FILE: hw/rtl/splq_pkg.sv
// shared constants, codes and helpers for the shared-pool linked queues
package splq_pkg;

   localparam int ENTRIES      = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int QUEUES       = 2;
   localparam int IDX_WIDTH    = $clog2(ENTRIES);
   localparam int LINK_WIDTH   = $clog2(ENTRIES + 1);

   localparam int CMD_WIDTH    = 2;
   localparam int QSEL_WIDTH   = 1;
   localparam int DIN_WIDTH    = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int DOUT_WIDTH   = 32;

   // a link equal to the entry count is the null link
   localparam logic [LINK_WIDTH-1:0] NIL_LINK = LINK_WIDTH'(ENTRIES);

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_PEEK    = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef logic [LINK_WIDTH-1:0] link_type;
   typedef logic [IDX_WIDTH-1:0]  idx_type;
   typedef logic [DATA_WIDTH-1:0] data_type;

   function automatic logic is_entry(link_type link);
      return link < NIL_LINK;
   endfunction

   // entry index of a link, zero for the null link
   function automatic idx_type link_idx(link_type link);
      return is_entry(link) ? link[IDX_WIDTH-1:0] : '0;
   endfunction

endpackage

FILE: hw/rtl/splq_req_if.sv
// request channel: command, queue select and data word with valid/ready
interface splq_req_if;
   logic                               valid;
   logic                               ready;
   logic [splq_pkg::CMD_WIDTH-1:0]     command;
   logic [splq_pkg::QSEL_WIDTH-1:0]    queue_select;
   logic [splq_pkg::DIN_WIDTH-1:0]     data_in;

   modport source (output valid, output command, output queue_select, output data_in,
                   input ready);
   modport sink   (input valid, input command, input queue_select, input data_in,
                   output ready);
endinterface

FILE: hw/rtl/splq_rsp_if.sv
// response channel: status and data word with valid/ready
interface splq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [splq_pkg::STATUS_WIDTH-1:0]   status;
   logic [splq_pkg::DOUT_WIDTH-1:0]     data_out;

   modport source (output valid, output status, output data_out, input ready);
   modport sink   (input valid, input status, input data_out, output ready);
endinterface

FILE: hw/rtl/shared_pool_linked_queues_core.sv
// two linked-list fifo queues sharing one entry pool with a free list
//
//  channel   dir   handshake      payload
//  req_if    in    valid/ready    command, queue_select, data_in
//  rsp_if    out   valid/ready    status, data_out
//
// one transaction per cycle sustained while responses are not stalled; a request is
// registered, then decoded and applied to the pool as the response register loads,
// so the response comes from the response register behind the request register
// the throughput is set by the single link-store read and write per cycle
// synchronous reset puts every entry on the free list at once, no sweep
// a stalled response holds the request register; req ready drops only then
module shared_pool_linked_queues_core (
   input  logic             clock,
   input  logic             reset,
   splq_req_if.sink         req_if,
   splq_rsp_if.source       rsp_if
);

   // request register
   logic                                in_valid_ff;
   splq_pkg::cmd_type                   in_cmd_ff;
   logic [splq_pkg::QSEL_WIDTH-1:0]     in_qsel_ff;
   splq_pkg::data_type                  in_data_ff;

   // response register
   logic                                rsp_valid_ff;
   splq_pkg::status_type                rsp_status_ff;
   logic [splq_pkg::DOUT_WIDTH-1:0]     rsp_data_ff;
   splq_pkg::status_type                rsp_status_in;
   logic [splq_pkg::DOUT_WIDTH-1:0]     rsp_data_in;

   // pool state
   splq_pkg::data_type                  payload_ff [splq_pkg::ENTRIES];
   splq_pkg::link_type                  link_ff    [splq_pkg::ENTRIES];
   splq_pkg::link_type                  free_head_ff;
   splq_pkg::link_type                  free_head_in;
   splq_pkg::link_type                  head_ff    [splq_pkg::QUEUES];
   splq_pkg::link_type                  head_in    [splq_pkg::QUEUES];
   splq_pkg::link_type                  tail_ff    [splq_pkg::QUEUES];
   splq_pkg::link_type                  tail_in    [splq_pkg::QUEUES];

   // store write ports
   logic                                lk_we;
   splq_pkg::idx_type                   lk_addr;
   splq_pkg::link_type                  lk_data;
   logic                                pl_we;

   // decode helpers
   logic                                advance;
   splq_pkg::link_type                  cur_head;
   splq_pkg::link_type                  cur_tail;
   splq_pkg::link_type                  rd_addr;
   splq_pkg::link_type                  rd_link;
   splq_pkg::link_type                  next_head;
   splq_pkg::data_type                  head_data;

   // the pending request moves on when the response slot is free or draining
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.data_out = rsp_data_ff;

   assign cur_head = head_ff[in_qsel_ff];
   assign cur_tail = tail_ff[in_qsel_ff];

   // single link read: free-list successor for enqueue, queue successor otherwise
   assign rd_addr   = (in_cmd_ff == splq_pkg::CMD_ENQUEUE) ? free_head_ff : cur_head;
   assign rd_link   = link_ff[splq_pkg::link_idx(rd_addr)];
   assign head_data = payload_ff[splq_pkg::link_idx(cur_head)];

   // the tail entry always ends its queue, so its stored link is never followed
   assign next_head = (cur_head == cur_tail) ? splq_pkg::NIL_LINK : rd_link;

   always_comb begin
      free_head_in  = free_head_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      lk_we         = 1'b0;
      lk_addr       = splq_pkg::link_idx(free_head_ff);
      lk_data       = free_head_ff;
      pl_we         = 1'b0;
      rsp_status_in = splq_pkg::STATUS_OK;
      rsp_data_in   = '0;

      case (in_cmd_ff)
         splq_pkg::CMD_ENQUEUE: begin
            if (!splq_pkg::is_entry(free_head_ff)) begin
               rsp_status_in = splq_pkg::STATUS_FULL;
            end else begin
               pl_we        = 1'b1;
               free_head_in = rd_link;
               tail_in[in_qsel_ff] = free_head_ff;
               if (!splq_pkg::is_entry(cur_tail)) begin
                  head_in[in_qsel_ff] = free_head_ff;
               end else begin
                  // append behind the current tail
                  lk_we   = 1'b1;
                  lk_addr = splq_pkg::link_idx(cur_tail);
                  lk_data = free_head_ff;
               end
            end
         end
         splq_pkg::CMD_DEQUEUE: begin
            if (!splq_pkg::is_entry(cur_head) || !splq_pkg::is_entry(cur_tail)) begin
               rsp_status_in = splq_pkg::STATUS_EMPTY;
            end else begin
               rsp_data_in         = splq_pkg::DOUT_WIDTH'(head_data);
               head_in[in_qsel_ff] = next_head;
               if (!splq_pkg::is_entry(next_head)) begin
                  tail_in[in_qsel_ff] = splq_pkg::NIL_LINK;
               end
               // freed entry goes to the front of the free list
               lk_we        = 1'b1;
               lk_addr      = splq_pkg::link_idx(cur_head);
               lk_data      = free_head_ff;
               free_head_in = cur_head;
            end
         end
         splq_pkg::CMD_PEEK: begin
            if (!splq_pkg::is_entry(cur_head)) begin
               rsp_status_in = splq_pkg::STATUS_EMPTY;
            end else begin
               rsp_data_in = splq_pkg::DOUT_WIDTH'(head_data);
            end
         end
         default: begin
            // unused command code: plain ok, nothing changes
            rsp_status_in = splq_pkg::STATUS_OK;
         end
      endcase
   end

   // control state, list pointers and link store
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
         for (int q = 0; q < splq_pkg::QUEUES; q++) begin
            head_ff[q] <= splq_pkg::NIL_LINK;
            tail_ff[q] <= splq_pkg::NIL_LINK;
         end
         // every entry chained on the free list, last one ends it
         for (int k = 0; k < splq_pkg::ENTRIES; k++) begin
            link_ff[k] <= splq_pkg::LINK_WIDTH'(k + 1);
         end
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            free_head_ff <= free_head_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            if (lk_we) begin
               link_ff[lk_addr] <= lk_data;
            end
         end
      end
   end

   // payload registers: request, response and pool data words
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_cmd_ff  <= splq_pkg::cmd_type'(req_if.command);
         in_qsel_ff <= req_if.queue_select;
         in_data_ff <= splq_pkg::DATA_WIDTH'(req_if.data_in);
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         if (pl_we) begin
            payload_ff[splq_pkg::link_idx(free_head_ff)] <= in_data_ff;
         end
      end
   end

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the two linked-list queues sharing one entry pool
module tb_top;

   // command code that the block must ignore; not a member of cmd_type
   localparam logic [splq_pkg::CMD_WIDTH-1:0] CMD_RESERVED = 2'd3;
   localparam int RANDOM_ITEMS = 1620;
   localparam int PHASE_ITEMS  = 64;
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset;

   splq_req_if req_ch ();
   splq_rsp_if rsp_ch ();

   shared_pool_linked_queues_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // one row of the directed table; reps repeats the row with the data word
   // xored with the repeat index
   typedef struct packed {
      logic [splq_pkg::CMD_WIDTH-1:0]    command;
      logic [splq_pkg::QSEL_WIDTH-1:0]   queue_select;
      logic [splq_pkg::DIN_WIDTH-1:0]    data_in;
      int                                reps;
      bit                                typed;
      logic [splq_pkg::STATUS_WIDTH-1:0] status;
      logic [splq_pkg::DOUT_WIDTH-1:0]   data_out;
   } stim_row;

   typedef struct packed {
      logic [splq_pkg::STATUS_WIDTH-1:0] status;
      logic [splq_pkg::DOUT_WIDTH-1:0]   data_out;
   } pool_response;

   // private copy of the pool: payloads, links, free list and queue ends
   splq_pkg::data_type pool_payload [splq_pkg::ENTRIES];
   splq_pkg::link_type pool_link [splq_pkg::ENTRIES];
   splq_pkg::link_type free_top;
   splq_pkg::link_type head_of [splq_pkg::QUEUES];
   splq_pkg::link_type tail_of [splq_pkg::QUEUES];

   pool_response pending_responses [$];

   int  error_count;
   int  response_count;
   int  cmd_count [4];
   int  full_count;
   int  empty_count;
   bit  gapless;

   stim_row directed_table [0:14];

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit on the run, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d responses still pending", pending_responses.size());
      $display("FAIL");
      $finish;
   end

   // state after reset: every entry on the free list in index order
   task automatic reset_pool_model();
      for (int k = 0; k < splq_pkg::ENTRIES; k++) begin
         pool_payload[k] = '0;
         pool_link[k]    = splq_pkg::link_type'(k + 1);
      end
      pool_link[splq_pkg::ENTRIES-1] = splq_pkg::NIL_LINK;
      free_top = '0;
      for (int k = 0; k < splq_pkg::QUEUES; k++) begin
         head_of[k] = splq_pkg::NIL_LINK;
         tail_of[k] = splq_pkg::NIL_LINK;
      end
   endtask

   // successor of an entry, any out-of-range link reads as null
   function automatic splq_pkg::link_type follow_link(splq_pkg::link_type e);
      splq_pkg::link_type n;
      if (e >= splq_pkg::NIL_LINK)
         return splq_pkg::NIL_LINK;
      n = pool_link[e[splq_pkg::IDX_WIDTH-1:0]];
      return (n < splq_pkg::NIL_LINK) ? n : splq_pkg::NIL_LINK;
   endfunction

   // applies one transaction to the pool copy and returns the response it gives
   function automatic pool_response predict_response(
         logic [splq_pkg::CMD_WIDTH-1:0]  command,
         logic [splq_pkg::QSEL_WIDTH-1:0] qsel,
         logic [splq_pkg::DIN_WIDTH-1:0]  word);
      pool_response       r;
      splq_pkg::link_type e;
      r.status   = splq_pkg::STATUS_OK;
      r.data_out = '0;
      case (command)
         splq_pkg::CMD_ENQUEUE: begin
            e = free_top;
            if (e >= splq_pkg::NIL_LINK) begin
               // pool exhausted, nothing moves
               r.status = splq_pkg::STATUS_FULL;
            end else begin
               free_top = follow_link(e);
               pool_payload[e[splq_pkg::IDX_WIDTH-1:0]] = splq_pkg::data_type'(word);
               pool_link[e[splq_pkg::IDX_WIDTH-1:0]]    = splq_pkg::NIL_LINK;
               if (tail_of[qsel] >= splq_pkg::NIL_LINK) begin
                  head_of[qsel] = e;
               end else begin
                  pool_link[tail_of[qsel][splq_pkg::IDX_WIDTH-1:0]] = e;
               end
               tail_of[qsel] = e;
            end
         end
         splq_pkg::CMD_DEQUEUE: begin
            e = head_of[qsel];
            if (tail_of[qsel] >= splq_pkg::NIL_LINK || e >= splq_pkg::NIL_LINK) begin
               r.status = splq_pkg::STATUS_EMPTY;
            end else begin
               r.data_out    = pool_payload[e[splq_pkg::IDX_WIDTH-1:0]];
               head_of[qsel] = follow_link(e);
               if (head_of[qsel] >= splq_pkg::NIL_LINK)
                  tail_of[qsel] = splq_pkg::NIL_LINK;
               // freed entry goes back on the front of the free list
               pool_link[e[splq_pkg::IDX_WIDTH-1:0]] = free_top;
               free_top = e;
            end
         end
         splq_pkg::CMD_PEEK: begin
            e = head_of[qsel];
            if (e >= splq_pkg::NIL_LINK)
               r.status = splq_pkg::STATUS_EMPTY;
            else
               r.data_out = pool_payload[e[splq_pkg::IDX_WIDTH-1:0]];
         end
         default: begin
            // reserved code: ignored, plain ok with zero data
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on response %0d: %s got %h expected %h",
               response_count, field, got, want);
      error_count++;
   endtask

   // drives one request transaction, waits for its acceptance and queues the
   // expected response; valid stays high on return
   task automatic send_request(logic [splq_pkg::CMD_WIDTH-1:0] command,
                               logic [splq_pkg::QSEL_WIDTH-1:0] qsel,
                               logic [splq_pkg::DIN_WIDTH-1:0] word,
                               bit typed,
                               pool_response typed_response);
      int           gap;
      pool_response predicted;
      gap = gapless ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= command;
      req_ch.queue_select <= qsel;
      req_ch.data_in      <= word;
      do @(posedge clock); while (!req_ch.ready);
      // accepted at this edge
      predicted = predict_response(command, qsel, word);
      pending_responses.push_back(typed ? typed_response : predicted);
      cmd_count[command]++;
   endtask

   // response side: random stalls on ready, every response checked in order
   initial begin
      pool_response want;
      int           stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = gapless ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         response_count++;
         if (pending_responses.size() == 0) begin
            $display("unexpected response %0d: status %h data %h",
                     response_count, rsp_ch.status, rsp_ch.data_out);
            error_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
            if (rsp_ch.data_out !== want.data_out)
               report_mismatch("data_out", rsp_ch.data_out, want.data_out);
            if (want.status == splq_pkg::STATUS_FULL)
               full_count++;
            if (want.status == splq_pkg::STATUS_EMPTY)
               empty_count++;
         end
      end
   end

   // stimulus
   initial begin
      pool_response typed_rsp;
      logic [splq_pkg::CMD_WIDTH-1:0]  command;
      logic [splq_pkg::QSEL_WIDTH-1:0] qsel;
      logic [splq_pkg::DIN_WIDTH-1:0]  word;
      int  counted;
      int  pick;
      bit  fill_phase;

      error_count    = 0;
      response_count = 0;
      full_count     = 0;
      empty_count    = 0;
      gapless        = 1'b0;
      for (int k = 0; k < 4; k++)
         cmd_count[k] = 0;

      // every input known from time zero
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.command      <= splq_pkg::CMD_ENQUEUE;
      req_ch.queue_select <= '0;
      req_ch.data_in      <= '0;
      reset_pool_model();

      directed_table = '{
         // both queues empty right after reset, reserved code ignored
         '{splq_pkg::CMD_DEQUEUE, 1'b0, 32'h0000_0000, 1, 1'b1,
           splq_pkg::STATUS_EMPTY, 32'h0},
         '{splq_pkg::CMD_PEEK,    1'b1, 32'h0000_0000, 1, 1'b1,
           splq_pkg::STATUS_EMPTY, 32'h0},
         '{CMD_RESERVED,          1'b1, 32'hDEAD_BEEF, 1, 1'b1,
           splq_pkg::STATUS_OK,    32'h0},
         // extreme data words through both queues
         '{splq_pkg::CMD_ENQUEUE, 1'b0, 32'hFFFF_FFFF, 1, 1'b1,
           splq_pkg::STATUS_OK,    32'h0},
         '{splq_pkg::CMD_ENQUEUE, 1'b1, 32'h0000_0000, 1, 1'b1,
           splq_pkg::STATUS_OK,    32'h0},
         '{splq_pkg::CMD_PEEK,    1'b0, 32'h0000_0000, 1, 1'b1,
           splq_pkg::STATUS_OK,    32'hFFFF_FFFF},
         '{splq_pkg::CMD_PEEK,    1'b1, 32'hFFFF_FFFF, 1, 1'b1,
           splq_pkg::STATUS_OK,    32'h0},
         '{splq_pkg::CMD_DEQUEUE, 1'b0, 32'h5555_5555, 1, 1'b1,
           splq_pkg::STATUS_OK,    32'hFFFF_FFFF},
         '{splq_pkg::CMD_DEQUEUE, 1'b0, 32'h0000_0000, 1, 1'b1,
           splq_pkg::STATUS_EMPTY, 32'h0},
         '{splq_pkg::CMD_DEQUEUE, 1'b1, 32'hAAAA_AAAA, 1, 1'b1,
           splq_pkg::STATUS_OK,    32'h0},
         // fill the whole pool from both queues, then one more
         '{splq_pkg::CMD_ENQUEUE, 1'b0, 32'h1234_0000, 8, 1'b0,
           splq_pkg::STATUS_OK,    32'h0},
         '{splq_pkg::CMD_ENQUEUE, 1'b1, 32'h5678_0000, 8, 1'b0,
           splq_pkg::STATUS_OK,    32'h0},
         '{splq_pkg::CMD_ENQUEUE, 1'b1, 32'h0000_CAFE, 1, 1'b1,
           splq_pkg::STATUS_FULL,  32'h0},
         '{splq_pkg::CMD_PEEK,    1'b1, 32'h0000_0000, 1, 1'b0,
           splq_pkg::STATUS_OK,    32'h0},
         '{splq_pkg::CMD_DEQUEUE, 1'b0, 32'h0000_0000, 1, 1'b0,
           splq_pkg::STATUS_OK,    32'h0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, expectations typed in where marked
      foreach (directed_table[i]) begin
         for (int rep = 0; rep < directed_table[i].reps; rep++) begin
            typed_rsp.status   = directed_table[i].status;
            typed_rsp.data_out = directed_table[i].data_out;
            send_request(directed_table[i].command, directed_table[i].queue_select,
                         directed_table[i].data_in ^ splq_pkg::DIN_WIDTH'(rep),
                         directed_table[i].typed, typed_rsp);
         end
      end

      // random part: alternating fill-heavy and drain-heavy phases so the
      // pool runs into full and the queues into empty again and again;
      // a reserved code now and then as noise, not counted
      typed_rsp = '0;
      counted   = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted % PHASE_ITEMS == 0) begin
            fill_phase = ((counted / PHASE_ITEMS) % 2) == 0;
            // some phases run with no idling on either side
            gapless = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 3)
            command = CMD_RESERVED;
         else if (fill_phase)
            command = (pick < 70) ? splq_pkg::CMD_ENQUEUE :
                      (pick < 88) ? splq_pkg::CMD_DEQUEUE : splq_pkg::CMD_PEEK;
         else
            command = (pick < 25) ? splq_pkg::CMD_ENQUEUE :
                      (pick < 80) ? splq_pkg::CMD_DEQUEUE : splq_pkg::CMD_PEEK;
         qsel = splq_pkg::QSEL_WIDTH'($urandom_range(0, 1));
         pick = $urandom_range(0, 9);
         word = (pick == 0) ? '1 : (pick == 1) ? '0 : splq_pkg::DIN_WIDTH'($urandom);
         send_request(command, qsel, word, 1'b0, typed_rsp);
         if (command != CMD_RESERVED)
            counted++;
      end

      // last transaction accepted at this edge, stop offering
      req_ch.valid  <= 1'b0;
      gapless       = 1'b0;

      // drain, then run on idle to catch any stray response
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d enqueue, %0d dequeue, %0d peek, %0d reserved transactions",
               cmd_count[splq_pkg::CMD_ENQUEUE], cmd_count[splq_pkg::CMD_DEQUEUE],
               cmd_count[splq_pkg::CMD_PEEK], cmd_count[CMD_RESERVED]);
      $display("%0d responses checked, %0d pool full, %0d queue empty, %0d errors",
               response_count, full_count, empty_count, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: shared_pool_linked_queues_core.f
hw/rtl/splq_pkg.sv
hw/rtl/splq_req_if.sv
hw/rtl/splq_rsp_if.sv
hw/rtl/shared_pool_linked_queues_core.sv
sim/tb_top.sv
